[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define NTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define NTG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/ntg_pkg.sv]
// Shared constants, types and elaboration-time table builders for the tone generator.
package ntg_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int NOTE_W    = 9;
    localparam int RATE_W    = 18;
    localparam int CFG_IDX_W = 1;
    localparam int AMP_W     = 40;   // 440 * 2^(k/12) in Q30 fits in 40 bits

    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_MODE = 1'b1;
    localparam logic [RATE_W-1:0]    RATE_RST      = 18'd44100;

    localparam int NOTE_BASE = 57;   // character code mapped to A440
    localparam int NOTE_MIN  = -96;
    localparam int NOTE_MAX  = 63;
    localparam int RECIP12   = 171;  // floor(v*171/2048) == floor(v/12) for v < 160

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] SEMI_Q30   = 64'd1137589835;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] A4_HZ      = 64'd440;

    // Taylor divisors (2k)(2k+1), indexed by k.
    localparam logic [7:0] HORNER_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                8'd110, 8'd156, 8'd210};

    typedef struct packed {
        logic capture;
        logic div_start;
        logic step_load;
        logic rom_read;
        logic out_load;
    } ntg_cmd_t;

    typedef struct packed {
        logic div_done;
    } ntg_stat_t;

    // 440 * (2^(1/12))^k in Q30, k = 0..11.
    function automatic logic [63:0] note_amp(input int k);
        logic [63:0] r;
        r = Q30_ONE;
        for (int i = 0; i < k; i++)
        begin
            r = (r * SEMI_Q30) >> 30;
        end
        return A4_HZ * r;
    endfunction

    // Quarter-wave magnitude for table index m, already scaled to the sample amplitude.
    function automatic logic [63:0] sine_mag(input int m, input int sab, input int sbits);
        logic [63:0] quarter;
        logic [63:0] amp;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        quarter = 64'd1 << (sab - 2);
        amp     = (64'd1 << (sbits - 1)) - 64'd1;
        if (m == 0)
        begin
            s = 64'd0;
        end
        else if (64'(m) >= quarter)
        begin
            s = Q30_ONE;
        end
        else
        begin
            x  = (64'(m) * TWO_PI_Q30) >> sab;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int k = 7; k >= 1; k--)
            begin
                t = Q30_ONE - ((x2 * t) >> 30) / HORNER_DIV[k];
            end
            t = (x * t) >> 30;
            if (t > Q30_ONE)
            begin
                t = Q30_ONE;
            end
            s = t;
        end
        return (s * amp) >> 30;
    endfunction

endpackage

[hw/rtl/note_sine_tone_generator.sv]
// Top level of the equal-tempered note sine tone generator.
// Usage:
//   Input channel (in_valid/in_ready): one request carries note_value and new_note.
//   new_note=1 turns the note into a phase step (440*2^(n/12)/rate turns,
//   offset clamped to -96..+63) and restarts the phase at zero; new_note=0 keeps going.
//   note_mode=1 reads note_value as a character code minus 57.
//   Output channel (out_valid/out_ready): one signed sample per request, sine of the
//   current phase scaled to full range and truncated toward zero; phase then advances.
//   Config port: cfg_we writes cfg_wdata to register cfg_addr (0 output rate,
//   1 note_mode) in the same cycle; write only while no request is in flight.
// Sequence:
//   Plain request: after acceptance the controller reads the table, then loads the
//   output register once it is free and raises out_valid; the next request is taken
//   back in idle. A new note first passes a prep state and the restoring divider that
//   makes the step (DIV_W = PHASE_BITS+15, or 40 if PHASE_BITS <= 25; 47 by default).
//   The output register frees the controller: the next request is taken while the
//   last sample waits; a stalled receiver holds the block only when a second sample
//   is ready to load.
// Reset: rate=44100, note_mode=0, phase and step zero (samples read 0 until
//   a note starts). No clearing pass.
module note_sine_tone_generator #(
    parameter int PHASE_BITS     = ntg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = ntg_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = ntg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ntg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ntg_pkg::RATE_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ntg_pkg::NOTE_W-1:0] note_value,
    input  logic                              new_note,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]     sample
);

    ntg_pkg::ntg_cmd_t  cmd;
    ntg_pkg::ntg_stat_t stat;

    // sequencing: accept, optional step division, table read, output load
    ntg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .new_note  (new_note),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic, config registers, phase state and sample register
    ntg_dp #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .note_value (note_value),
        .cmd        (cmd),
        .stat       (stat),
        .sample     (sample)
    );

endmodule

[hw/rtl/ntg_div.sv]
// Restoring divider, one quotient bit per cycle.
module ntg_div #(
    parameter int DIVIDEND_W = 47,
    parameter int DIVISOR_W  = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

[hw/rtl/ntg_dp.sv]
// Datapath: config registers, note-to-step conversion, phase accumulator, sine lookup.
module ntg_dp #(
    parameter int PHASE_BITS     = ntg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = ntg_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = ntg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ntg_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ntg_pkg::RATE_W-1:0]         cfg_wdata,
    input  logic signed [ntg_pkg::NOTE_W-1:0]  note_value,
    input  ntg_pkg::ntg_cmd_t                  cmd,
    output ntg_pkg::ntg_stat_t                 stat,
    output logic signed [SAMPLE_BITS-1:0]      sample
);

    localparam int AMP_W     = ntg_pkg::AMP_W;
    localparam int DIV_W     = (PHASE_BITS > 25) ? AMP_W + PHASE_BITS - 25 : AMP_W;
    localparam int QTR_W     = SINE_ADDR_BITS - 2;
    localparam int ROM_DEPTH = 1 << QTR_W;
    localparam int MAG_W     = SAMPLE_BITS - 1;
    localparam logic signed [7:0] E_OFS = 8'(PHASE_BITS - 38);
    localparam logic [MAG_W-1:0]  AMPLITUDE = {MAG_W{1'b1}};

    // config and state
    logic [ntg_pkg::RATE_W-1:0]        rate_reg, rate_next;
    logic                              note_mode_reg, note_mode_next;
    logic signed [ntg_pkg::NOTE_W-1:0] note_reg, note_next;
    logic [PHASE_BITS-1:0]             phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0]             phase_step_reg, phase_step_next;
    logic [MAG_W-1:0]                  rom_q_reg, rom_q_next;
    logic                              full_reg, full_next;
    logic                              neg_reg, neg_next;
    logic [SAMPLE_BITS-1:0]            sample_reg, sample_next;

    // constant tables
    logic [AMP_W-1:0] amp_tab [12];
    logic [MAG_W-1:0] sine_tab [ROM_DEPTH];

    for (genvar g = 0; g < 12; g++)
    begin : g_amp
        assign amp_tab[g] = AMP_W'(ntg_pkg::note_amp(g));
    end

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_sine
        assign sine_tab[g] = MAG_W'(ntg_pkg::sine_mag(g, SINE_ADDR_BITS, SAMPLE_BITS));
    end

    // note to divider operand
    logic signed [10:0] n_ext;
    logic signed [10:0] n_mode;
    logic signed [10:0] n_cl;
    logic [7:0]         v;
    logic [15:0]        v_prod;
    logic [4:0]         oct;
    logic [3:0]         semi;
    logic signed [7:0]  e;
    logic [7:0]         e_neg;
    logic [DIV_W-1:0]   amp_ext;
    logic [DIV_W-1:0]   dividend;
    logic [DIV_W-1:0]   quotient;
    logic               div_done;

    always_comb
    begin
        n_ext  = 11'(note_reg);
        n_mode = note_mode_reg ? n_ext - 11'(ntg_pkg::NOTE_BASE) : n_ext;
        if (n_mode < 11'(ntg_pkg::NOTE_MIN))
        begin
            n_cl = 11'(ntg_pkg::NOTE_MIN);
        end
        else if (n_mode > 11'(ntg_pkg::NOTE_MAX))
        begin
            n_cl = 11'(ntg_pkg::NOTE_MAX);
        end
        else
        begin
            n_cl = n_mode;
        end
        v        = 8'(n_cl - 11'(ntg_pkg::NOTE_MIN));
        v_prod   = 16'(v) * 16'(ntg_pkg::RECIP12);
        oct      = v_prod[15:11];
        semi     = 4'(v - 8'(oct) * 8'd12);
        e        = signed'({3'b000, oct}) + E_OFS;
        e_neg    = 8'(-e);
        amp_ext  = DIV_W'(amp_tab[semi]);
        dividend = e[7] ? (amp_ext >> e_neg[5:0]) : (amp_ext << e[5:0]);
    end

    ntg_div #(
        .DIVIDEND_W(DIV_W),
        .DIVISOR_W (ntg_pkg::RATE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (rate_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign stat.div_done = div_done;

    // phase to table index, quarter-wave folding
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [QTR_W-1:0]          j;
    logic [QTR_W-1:0]          rom_addr;
    logic [MAG_W-1:0]          mag;

    always_comb
    begin
        idx      = phase_acc_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        quad     = idx[SINE_ADDR_BITS-1:SINE_ADDR_BITS-2];
        j        = idx[QTR_W-1:0];
        rom_addr = quad[0] ? QTR_W'(-j) : j;
        mag      = full_reg ? AMPLITUDE : rom_q_reg;
    end

    always_comb
    begin
        rate_next       = rate_reg;
        note_mode_next  = note_mode_reg;
        note_next       = note_reg;
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        rom_q_next      = rom_q_reg;
        full_next       = full_reg;
        neg_next        = neg_reg;
        sample_next     = sample_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                ntg_pkg::CFG_RATE:      rate_next      = cfg_wdata;
                ntg_pkg::CFG_NOTE_MODE: note_mode_next = cfg_wdata[0];
                default:                rate_next      = rate_reg;
            endcase
        end
        if (cmd.capture)
        begin
            note_next = note_value;
        end
        if (cmd.step_load)
        begin
            phase_step_next = (rate_reg == '0) ? '0 : quotient[PHASE_BITS-1:0];
            phase_acc_next  = '0;
        end
        if (cmd.rom_read)
        begin
            rom_q_next     = sine_tab[rom_addr];
            full_next      = quad[0] && (j == '0);
            neg_next       = quad[1];
            phase_acc_next = phase_acc_reg + phase_step_reg;
        end
        if (cmd.out_load)
        begin
            sample_next = neg_reg ? SAMPLE_BITS'(-{1'b0, mag}) : {1'b0, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= ntg_pkg::RATE_RST;
            note_mode_reg  <= 1'b0;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
        end
        else
        begin
            rate_reg       <= rate_next;
            note_mode_reg  <= note_mode_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg   <= note_next;
        rom_q_reg  <= rom_q_next;
        full_reg   <= full_next;
        neg_reg    <= neg_next;
        sample_reg <= sample_next;
    end

    assign sample = signed'(sample_reg);

endmodule

[hw/rtl/ntg_ctrl.sv]
// Controller: request sequencing and output register valid.
module ntg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               new_note,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ntg_pkg::ntg_cmd_t  cmd,
    input  ntg_pkg::ntg_stat_t stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_FORM = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = new_note ? ST_PREP : ST_READ;
                end
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.step_load = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rom_read = 1'b1;
                state_next   = ST_FORM;
            end
            ST_FORM:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/ntg_chk.sv]
// Port-level checker for the tone generator and its bind.
`include "assert_macros.svh"

module ntg_chk #(
    parameter int SAMPLE_BITS = ntg_pkg::SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   new_note,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample
);

    // a stalled sample holds
    `NTG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(sample), "stalled sample changed")

    // magnitude never exceeds full scale, so the most negative code never shows
    `NTG_ASSERT(a_no_min_code, out_valid |-> !(sample[SAMPLE_BITS-1] && (sample[SAMPLE_BITS-2:0] == '0)), "sample out of range")

    // one request at a time
    `NTG_ASSERT(a_one_inflight, in_valid && in_ready |=> !in_ready, "request accepted while busy")

    // a plain request is not lost: out_valid follows its acceptance
    `NTG_ASSERT(a_plain_latency, in_valid && in_ready && !new_note |-> ##3 out_valid, "sample lost")

endmodule

bind note_sine_tone_generator ntg_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_ntg_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .new_note  (new_note),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
);
